/* hdl/ealc_pkg.sv */
// Package for the encoder angle LUT correction block.
// Holds the fixed field widths, channel packing widths, mode codes and turn constants.
// No dependencies.
package ealc_pkg;

  localparam int IDX_W = 7;
  localparam int CV_W  = 16;
  localparam int RAW_W = 12;
  localparam int ANG_W = 28;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_TDATA_W = 8;

  localparam int COUNTS_PER_TURN = 4096;
  localparam int CDEG_PER_TURN   = 36000;
  localparam longint TURN_SCALED = 64'(CDEG_PER_TURN) * 64'(COUNTS_PER_TURN);

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

endpackage

/* hdl/encoder_angle_lut_correction_top.sv */
// Encoder angle LUT correction, top level: handshake, pipeline registers, config register.
// Depends on ealc_pkg, ealc_table, ealc_interp and ealc_wrap.
//
// Usage:
//   in_*  : stream of items. in_tuser is the mode (0 load a table node, 1 convert).
//           Load writes correction_value at table_index; convert corrects raw_count.
//   out_* : one result item per input item, in order. out_tuser is angle_valid.
//   cfg_* : write of calibration_enable (bit 0); always ready. Write only while idle.
// Pipeline: four stages (input register, table read register, interpolation register,
//   output register). Throughput: one item per cycle while out_tready is high; the
//   table RAM reads both interpolation nodes at once.
// Reset: the table is cleared by a pass over all NODE_COUNT entries, one entry per cycle;
//   in_tready stays low during that pass. calibration_enable resets to 0.
// Stall: each stage advances when the next is empty or advancing, so the pipeline
//   keeps filling while out_tready is low; in_tready drops when all stages are full.
module encoder_angle_lut_correction_top #(
  parameter int NODE_COUNT      = 128,
  parameter int COUNTS_PER_NODE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [6:0] table_index, [22:7] correction_value, [34:23] raw_count, [39:35] zero
  input  logic [ealc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] mode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [27:0] corrected_angle, [55:28] applied_correction
  output logic [ealc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] angle_valid
  output logic                                out_tuser,
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  // [0] calibration_enable, [7:1] zero
  input  logic [ealc_pkg::CFG_TDATA_W-1:0]    cfg_tdata
);

  localparam int RW    = ealc_pkg::RAW_W;
  localparam int FW    = (COUNTS_PER_NODE > 1) ? $clog2(COUNTS_PER_NODE) : 1;
  localparam int SUM_W = FW + 18;
  localparam int AGW   = ealc_pkg::ANG_W;

  localparam int     Q_S = RW + $clog2(COUNTS_PER_NODE);
  localparam longint Q_M = ((64'd1 << Q_S) + COUNTS_PER_NODE - 1) / COUNTS_PER_NODE;
  localparam longint W_D = 64'(COUNTS_PER_NODE) * 64'(NODE_COUNT);
  localparam int     W_S = RW + $clog2(W_D);
  localparam longint W_M = ((64'd1 << W_S) + W_D - 1) / W_D;

  logic en0, en1, en2, en3;
  logic in_acc;
  logic tbl_busy;

  logic cal_en_r;

  logic v0_r, v1_r, v2_r, v3_r;

  logic                        mode0_r;
  logic [ealc_pkg::IDX_W-1:0]  idx0_r;
  logic [ealc_pkg::CV_W-1:0]   cv0_r;
  logic [RW-1:0]               raw0_r;
  logic [RW-1:0]               q0_r, w0_r;
  logic [47:0]                 q_prod, w_prod;
  logic [RW-1:0]               raw_in;

  logic [FW-1:0]               frac;
  logic [ealc_pkg::CV_W-1:0]   lo, hi;

  logic                        mode1_r;
  logic [RW-1:0]               raw1_r;
  logic [FW-1:0]               frac1_r;

  logic signed [SUM_W-1:0]     sum;
  logic [AGW-1:0]              base;
  logic                        mode2_r;
  logic signed [SUM_W-1:0]     sum2_r;
  logic [AGW-1:0]              base2_r;

  logic [AGW-1:0]              corrected, applied;
  logic [ealc_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                        out_tuser_r;

  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign en0       = !v0_r || en1;
  assign in_tready = en0 && !tbl_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;

  assign raw_in = in_tdata[34:23];
  assign q_prod = 48'(raw_in) * 48'(Q_M);
  assign w_prod = 48'(raw_in) * 48'(W_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_en_r <= 1'b0;
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        cal_en_r <= cfg_tdata[0];
      end
      if (en0) begin
        v0_r <= in_acc;
      end
      if (en1) begin
        v1_r <= v0_r;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      mode0_r <= in_tuser;
      idx0_r  <= in_tdata[6:0];
      cv0_r   <= in_tdata[22:7];
      raw0_r  <= raw_in;
      q0_r    <= RW'(q_prod >> Q_S);
      w0_r    <= RW'(w_prod >> W_S);
    end
    if (en1) begin
      mode1_r <= mode0_r;
      raw1_r  <= raw0_r;
      frac1_r <= frac;
    end
    if (en2) begin
      mode2_r <= mode1_r;
      sum2_r  <= sum;
      base2_r <= base;
    end
    if (en3) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= mode2_r;
    end
  end

  ealc_table #(
    .NODE_COUNT     (NODE_COUNT),
    .COUNTS_PER_NODE(COUNTS_PER_NODE),
    .FW             (FW)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_req(v0_r && (mode0_r == ealc_pkg::MODE_LOAD) && en1),
    .idx   (idx0_r),
    .cv    (cv0_r),
    .rd_en (en1),
    .raw   (raw0_r),
    .quo   (q0_r),
    .wraps (w0_r),
    .frac  (frac),
    .lo    (lo),
    .hi    (hi),
    .busy  (tbl_busy)
  );

  ealc_interp #(
    .COUNTS_PER_NODE(COUNTS_PER_NODE),
    .FW             (FW),
    .SUM_W          (SUM_W)
  ) u_interp (
    .lo  (lo),
    .hi  (hi),
    .frac(frac1_r),
    .raw (raw1_r),
    .sum (sum),
    .base(base)
  );

  ealc_wrap #(
    .COUNTS_PER_NODE(COUNTS_PER_NODE),
    .SUM_W          (SUM_W)
  ) u_wrap (
    .cal_en   (cal_en_r),
    .sum      (sum2_r),
    .base     (base2_r),
    .corrected(corrected),
    .applied  (applied)
  );

  always_comb begin
    if (mode2_r == ealc_pkg::MODE_CONVERT) begin
      out_tdata_nxt = {applied, corrected};
    end else begin
      out_tdata_nxt = '0;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* hdl/ealc_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module ealc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hdl/ealc_table.sv */
// Correction table: node/fraction decode, clearing pass after reset, table RAM.
// Depends on ealc_pkg and ealc_ram.
module ealc_table #(
  parameter int NODE_COUNT      = 128,
  parameter int COUNTS_PER_NODE = 32,
  parameter int FW              = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_req,
  input  logic [ealc_pkg::IDX_W-1:0]        idx,
  input  logic [ealc_pkg::CV_W-1:0]         cv,
  input  logic                              rd_en,
  input  logic [ealc_pkg::RAW_W-1:0]        raw,
  input  logic [ealc_pkg::RAW_W-1:0]        quo,
  input  logic [ealc_pkg::RAW_W-1:0]        wraps,
  output logic [FW-1:0]                     frac,
  output logic [ealc_pkg::CV_W-1:0]         lo,
  output logic [ealc_pkg::CV_W-1:0]         hi,
  output logic                              busy
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int RW = ealc_pkg::RAW_W;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] node, succ;
  logic [RW-1:0] frac_full;
  logic          idx_ok;
  logic          we;
  logic [AW-1:0] waddr;
  logic [ealc_pkg::CV_W-1:0] wdata;

  always_comb begin
    frac_full = raw - RW'(2 * RW'(quo) * RW'(COUNTS_PER_NODE) / 2);
    frac      = FW'(frac_full);
    node      = AW'(quo - RW'(wraps * RW'(NODE_COUNT)));
    succ      = (node == AW'(NODE_COUNT - 1)) ? '0 : AW'(node + 1'b1);
    idx_ok    = (13'(idx) < 13'(NODE_COUNT));
  end

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = AW'(clr_cnt_r + 1'b1);
      if (clr_cnt_r == AW'(NODE_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      we    = wr_req && idx_ok;
      waddr = AW'(idx);
      wdata = cv;
    end
  end

  assign busy = clr_busy_r;

  ealc_ram #(
    .WIDTH(ealc_pkg::CV_W),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (rd_en),
    .raddr_a(node),
    .raddr_b(succ),
    .rdata_a(lo),
    .rdata_b(hi)
  );

endmodule

/* hdl/ealc_interp.sv */
// Interpolation: node value*COUNTS_PER_NODE plus slope*fraction; raw angle in centidegrees*4096.
// Depends on ealc_pkg.
module ealc_interp #(
  parameter int COUNTS_PER_NODE = 32,
  parameter int FW              = 5,
  parameter int SUM_W           = 23
) (
  input  logic [ealc_pkg::CV_W-1:0]  lo,
  input  logic [ealc_pkg::CV_W-1:0]  hi,
  input  logic [FW-1:0]              frac,
  input  logic [ealc_pkg::RAW_W-1:0] raw,
  output logic signed [SUM_W-1:0]    sum,
  output logic [ealc_pkg::ANG_W-1:0] base
);

  localparam int AW = ealc_pkg::ANG_W;
  localparam logic signed [SUM_W-1:0] CPN_S = SUM_W'(COUNTS_PER_NODE);

  logic signed [ealc_pkg::CV_W-1:0] lo_s, hi_s;
  logic signed [ealc_pkg::CV_W:0]   diff;
  logic signed [FW:0]               frac_s;
  logic signed [SUM_W-1:0]          slope, lo_sc;

  always_comb begin
    lo_s   = $signed(lo);
    hi_s   = $signed(hi);
    diff   = (ealc_pkg::CV_W + 1)'(hi_s) - (ealc_pkg::CV_W + 1)'(lo_s);
    frac_s = $signed({1'b0, frac});
    slope  = SUM_W'(diff) * SUM_W'(frac_s);
    lo_sc  = SUM_W'(lo_s) * CPN_S;
    sum    = lo_sc + slope;
    base   = AW'(AW'(raw) * AW'(ealc_pkg::CDEG_PER_TURN));
  end

endmodule

/* hdl/ealc_wrap.sv */
// Final stage math: scale the correction to centidegrees*4096, add and wrap into one turn.
// Depends on ealc_pkg.
module ealc_wrap #(
  parameter int COUNTS_PER_NODE = 32,
  parameter int SUM_W           = 23
) (
  input  logic                       cal_en,
  input  logic signed [SUM_W-1:0]    sum,
  input  logic [ealc_pkg::ANG_W-1:0] base,
  output logic [ealc_pkg::ANG_W-1:0] corrected,
  output logic [ealc_pkg::ANG_W-1:0] applied
);

  localparam int SC_W  = 13;
  localparam int PW    = SUM_W + SC_W;
  localparam int SCALE = ealc_pkg::COUNTS_PER_TURN / COUNTS_PER_NODE;
  localparam logic signed [29:0] TURN = 30'(ealc_pkg::TURN_SCALED);

  logic signed [PW-1:0] corr_full;
  logic signed [28:0]   corr;
  logic signed [29:0]   tot, wrapped;

  always_comb begin
    corr_full = PW'(sum) * $signed(PW'(SCALE));
    corr      = cal_en ? $signed(corr_full[28:0]) : '0;
    tot       = $signed({2'b00, base}) + 30'(corr);
    if (tot < 0) begin
      wrapped = tot + TURN;
    end else if (tot >= TURN) begin
      wrapped = tot - TURN;
    end else begin
      wrapped = tot;
    end
    corrected = ealc_pkg::ANG_W'(wrapped);
    applied   = corr[ealc_pkg::ANG_W-1:0];
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for encoder_angle_lut_correction_top: table loads and angle converts.
// Predicts each result from its own copy of the calibration table and enable bit.
// Depends on ealc_pkg and the top level only.
module testbench;
  import ealc_pkg::*;

  localparam int NODE_COUNT      = 128;
  localparam int COUNTS_PER_NODE = 32;
  localparam int LATENCY         = 6;

  typedef struct packed {
    logic [ANG_W-1:0] corrected;
    logic [ANG_W-1:0] applied;
    logic             valid;
  } angle_result_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_style_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_tvalid = 1'b0;
  logic                   cfg_tready;
  logic [CFG_TDATA_W-1:0] cfg_tdata = '0;

  logic signed [CV_W-1:0] cal_table [NODE_COUNT];
  logic                   cal_enable;
  angle_result_t          pending_angles[$];
  int                     errors = 0;
  int                     burst_left = 0;
  int                     ready_timer = 0;
  int                     ready_phase = 0;
  ready_style_t           ready_style = RDY_ALWAYS;

  encoder_angle_lut_correction_top #(
    .NODE_COUNT(NODE_COUNT),
    .COUNTS_PER_NODE(COUNTS_PER_NODE)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Applies one item to the predicted state and returns its result.
  function automatic angle_result_t correct_angle(logic mode, logic [IDX_W-1:0] idx,
                                                  logic signed [CV_W-1:0] cv,
                                                  logic [RAW_W-1:0] raw);
    angle_result_t r;
    int     node, frac, succ;
    longint lo, hi, corr, total;
    r = '0;
    if (mode == MODE_LOAD) begin
      if (idx < NODE_COUNT) cal_table[idx] = cv;
      return r;
    end
    corr = 0;
    if (cal_enable) begin
      node = (int'(raw) / COUNTS_PER_NODE) % NODE_COUNT;
      frac = int'(raw) % COUNTS_PER_NODE;
      succ = (node + 1) % NODE_COUNT;
      lo   = cal_table[node];
      hi   = cal_table[succ];
      corr = (lo * COUNTS_PER_NODE + (hi - lo) * frac) * (COUNTS_PER_TURN / COUNTS_PER_NODE);
    end
    total = (longint'(raw) * CDEG_PER_TURN + corr) % TURN_SCALED;
    if (total < 0) total += TURN_SCALED;
    r.corrected = total[ANG_W-1:0];
    r.applied   = corr[ANG_W-1:0];
    r.valid     = 1'b1;
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %0d (0x%0h) got %0d (0x%0h)",
               $time, what, want, want, got, got);
  endtask

  always @(posedge clk) begin : check_results
    angle_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_angles.size() == 0) begin
        report("unexpected result item", 0, out_tdata);
      end else begin
        want = pending_angles.pop_front();
        if (out_tdata[ANG_W-1:0] != want.corrected)
          report("corrected_angle", want.corrected, out_tdata[ANG_W-1:0]);
        if (out_tdata[2*ANG_W-1:ANG_W] != want.applied)
          report("applied_correction", want.applied, out_tdata[2*ANG_W-1:ANG_W]);
        if (out_tuser != want.valid)
          report("angle_valid", want.valid, out_tuser);
      end
    end
  end

  // Receiver back-pressure: picks a random ready style and holds it for a random stretch set by ready_timer.
  always @(negedge clk) begin
    if (ready_timer == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      ready_timer = $urandom_range(50, 300);
    end
    ready_timer--;
    ready_phase++;
    case (ready_style)
      RDY_ALWAYS:   out_tready <= 1'b1;
      RDY_COIN:     out_tready <= $urandom_range(0, 1);
      RDY_SPARSE:   out_tready <= ($urandom_range(0, 7) == 0);
      default:      out_tready <= ((ready_phase % 5) < 2);
    endcase
  end

  task automatic send_item(logic mode, logic [IDX_W-1:0] idx, logic signed [CV_W-1:0] cv,
                           logic [RAW_W-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_TDATA_W'({raw, cv, idx});
    do @(posedge clk); while (!in_tready);
    pending_angles.push_back(correct_angle(mode, idx, cv, raw));
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_calibration(logic en);
    settle();
    @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= CFG_TDATA_W'(en);
    do @(posedge clk); while (!cfg_tready);
    cal_enable = en;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  task automatic test_cleared_table();
    set_calibration(1'b1);
    send_item(MODE_CONVERT, '0, '0, 12'd0);
    send_item(MODE_CONVERT, '1, '1, 12'd2047);
    send_item(MODE_CONVERT, '0, '0, 12'd4095);
  endtask

  task automatic test_node_extremes();
    send_item(MODE_LOAD, 7'd0,   16'sh8000, '1);
    send_item(MODE_LOAD, 7'd1,   16'sh7fff, '0);
    send_item(MODE_LOAD, 7'd127, 16'sh7fff, '0);
    send_item(MODE_LOAD, 7'd126, 16'sh8000, '1);
    send_item(MODE_LOAD, 7'd64,  16'shffff, '0);
    send_item(MODE_CONVERT, '1, '1, 12'd0);
    send_item(MODE_CONVERT, '0, '0, 12'd1);
    send_item(MODE_CONVERT, '0, '0, 12'd31);
    send_item(MODE_CONVERT, '0, '0, 12'd32);
    send_item(MODE_CONVERT, '0, '0, 12'd4063);
    send_item(MODE_CONVERT, '0, '0, 12'd4064);
    send_item(MODE_CONVERT, '0, '0, 12'd4095);
    send_item(MODE_CONVERT, '0, '0, 12'd2050);
    set_calibration(1'b0);
    send_item(MODE_CONVERT, '0, '0, 12'd4095);
    send_item(MODE_CONVERT, '0, '0, 12'd0);
    send_item(MODE_LOAD, 7'd0, 16'sh0000, '0);
  endtask

  task automatic test_table_sweep();
    int i;
    set_calibration(1'b1);
    for (i = 0; i < NODE_COUNT; i++)
      send_item(MODE_LOAD, IDX_W'(i), CV_W'($urandom), RAW_W'($urandom));
    repeat (40) send_item(MODE_CONVERT, IDX_W'($urandom), CV_W'($urandom), RAW_W'($urandom));
  endtask

  task automatic test_random_mix(int count, logic en);
    logic                   mode;
    logic [IDX_W-1:0]       idx;
    logic signed [CV_W-1:0] cv;
    logic [RAW_W-1:0]       raw;
    int                     pick;
    set_calibration(en);
    repeat (count) begin
      mode = ($urandom_range(0, 99) < 35) ? MODE_LOAD : MODE_CONVERT;
      idx  = IDX_W'($urandom);
      pick = $urandom_range(0, 9);
      cv   = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7fff : CV_W'($urandom);
      // half the time, aim raw at the node segment named by this item's idx
      raw  = ($urandom_range(0, 1) == 0) ? {idx, 5'($urandom)} : RAW_W'($urandom);
      send_item(mode, idx, cv, raw);
    end
  endtask

  initial begin
    foreach (cal_table[i]) cal_table[i] = '0;
    cal_enable = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_cleared_table();
    test_node_extremes();
    test_table_sweep();
    test_random_mix(230, 1'b1);
    test_random_mix(100, 1'b0);
    test_random_mix(200, 1'b1);
    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ealc_pkg.sv
hdl/ealc_ram.sv
hdl/ealc_table.sv
hdl/ealc_interp.sv
hdl/ealc_wrap.sv
hdl/encoder_angle_lut_correction_top.sv
tb/sv/testbench.sv
